/* sv/sop_eval_pkg.sv */
package sop_eval_pkg;

   // Deepest group nesting the stack holds by default.
   localparam int DEFAULT_MAX_DEPTH = 16;

   // Expression characters (ASCII).
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_BANG  = 8'h21;

   // One saved group context.
   typedef struct packed {
      logic neg;
      logic prod;
      logic sum;
   } stack_entry_type;

   localparam int STACK_ENTRY_W = $bits(stack_entry_type);

endpackage

/* sv/sop_eval_ram.sv */
module sop_eval_ram #(
   parameter int WIDTH = sop_eval_pkg::STACK_ENTRY_W,
   parameter int DEPTH = sop_eval_pkg::DEFAULT_MAX_DEPTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/sum_of_products_expression_evaluator.sv */
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_ready  req_character, req_var_values, req_last
// rsp      out        rsp_valid/rsp_ready  rsp_value, rsp_error
//
// One character per cycle while req_ready is high; a result appears the cycle
// after its last character is taken. The rate is set by the registered state update.
// Reset (synchronous, active high) clears the flags, nesting level and the
// result valid flag; the stack RAM is not cleared, its entries are always
// pushed before they are popped.
// req_ready stays high while the result register is empty or being drained.
module sum_of_products_expression_evaluator #(
   parameter int MAX_DEPTH = sop_eval_pkg::DEFAULT_MAX_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_character,
   input  logic [4:0] req_var_values,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_value,
   output logic       rsp_error
);

   // Level counts 0..MAX_DEPTH; stack address only needs 0..MAX_DEPTH-1.
   localparam int LW = $clog2(MAX_DEPTH + 1);
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam logic [LW-1:0] LEVEL_FULL = LW'(MAX_DEPTH);

   // Running state
   logic [LW-1:0] level_ff, level_in;
   logic          sum_ff, sum_in;
   logic          prod_ff, prod_in;
   logic          neg_ff, neg_in;
   logic          err_ff, err_in;

   // Top-of-stack bypass: a push writes the RAM and this register, since the
   // registered RAM read issued in the push cycle still returns the old entry.
   logic                           pushed_ff, pushed_in;
   sop_eval_pkg::stack_entry_type  byp_ff;

   // Result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_value_ff, rsp_value_in;
   logic rsp_error_ff, rsp_error_in;

   logic                          accept;
   logic                          do_push;
   sop_eval_pkg::stack_entry_type push_entry;
   sop_eval_pkg::stack_entry_type top_entry;
   logic [sop_eval_pkg::STACK_ENTRY_W-1:0] ram_rd;
   logic [AW-1:0]                 rd_level;
   logic [2:0]                    var_idx;
   logic                          var_bit;
   logic                          grp;
   logic                          fin_err;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign top_entry = pushed_ff ? byp_ff : sop_eval_pkg::stack_entry_type'(ram_rd);

   // Letter A..E picks bit 0..4.
   assign var_idx = 3'(req_character - sop_eval_pkg::CHAR_A);
   assign var_bit = req_var_values[var_idx];

   assign push_entry = '{neg: neg_ff, prod: prod_ff, sum: sum_ff};

   always_comb begin
      level_in     = level_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      do_push      = 1'b0;
      grp          = 1'b0;
      fin_err      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;

      if (accept) begin
         if (req_character >= sop_eval_pkg::CHAR_A &&
             req_character <= sop_eval_pkg::CHAR_E) begin
            prod_in = prod_ff && var_bit;
         end else begin
            case (req_character)
               sop_eval_pkg::CHAR_PLUS: begin
                  sum_in  = sum_ff || prod_ff;
                  prod_in = 1'b1;
               end
               sop_eval_pkg::CHAR_OPEN: begin
                  if (level_ff == LEVEL_FULL) begin
                     err_in = 1'b1;   // nesting overflow
                  end else begin
                     do_push  = 1'b1;
                     level_in = level_ff + 1'b1;
                     sum_in   = 1'b0;
                     prod_in  = 1'b1;
                     neg_in   = 1'b0;
                  end
               end
               sop_eval_pkg::CHAR_CLOSE: begin
                  if (level_ff == '0) begin
                     err_in = 1'b1;   // unmatched close
                  end else begin
                     grp      = (sum_ff || prod_ff) ^ top_entry.neg;
                     level_in = level_ff - 1'b1;
                     sum_in   = top_entry.sum;
                     prod_in  = top_entry.prod && grp;
                     neg_in   = 1'b0;  // stray negate inside the group is dropped
                  end
               end
               sop_eval_pkg::CHAR_BANG: begin
                  neg_in = 1'b1;
               end
               default: begin
               end
            endcase
         end

         if (req_last) begin
            fin_err      = err_in || (level_in != '0);
            rsp_valid_in = 1'b1;
            rsp_error_in = fin_err;
            rsp_value_in = !fin_err && (sum_in || prod_in);
            level_in     = '0;
            sum_in       = 1'b0;
            prod_in      = 1'b1;
            neg_in       = 1'b0;
            err_in       = 1'b0;
         end
      end

      pushed_in = do_push && !req_last;
   end

   // Read the entry that will be on top next cycle.
   assign rd_level = AW'(level_in - 1'b1);

   sop_eval_ram #(
      .WIDTH (sop_eval_pkg::STACK_ENTRY_W),
      .DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (level_ff[AW-1:0]),
      .wr_data (push_entry),
      .rd_addr (rd_level),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         sum_ff       <= 1'b0;
         prod_ff      <= 1'b1;
         neg_ff       <= 1'b0;
         err_ff       <= 1'b0;
         pushed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         sum_ff       <= sum_in;
         prod_ff      <= prod_in;
         neg_ff       <= neg_in;
         err_ff       <= err_in;
         pushed_ff    <= pushed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byp_ff       <= push_entry;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

   // Checks
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_FULL)
      else $error("nesting level beyond stack depth");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req_last |=> rsp_valid_ff)
      else $error("last word did not load a result");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last |=> level_ff == '0 && !err_ff && prod_ff && !sum_ff && !pushed_ff)
      else $error("state not cleared after last word");

   a_bypass_level: assert property (@(posedge clock) disable iff (reset)
      pushed_ff |-> level_ff != '0)
      else $error("bypass entry with empty stack");

   a_err_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_error_ff |-> !rsp_value_ff)
      else $error("value set together with error");

endmodule
